[rtl/psht_pkg.sv]
// package: constants, types and codes of the hotspot table
`default_nettype none
package psht_pkg;
    localparam int ENTRIES = 20;
    localparam int GRANULE = 16;
    localparam int IDX_W = 5;
    localparam int RAT_W = 11;

    localparam logic [2:0] ST_IGNORED = 3'd0;
    localparam logic [2:0] ST_HIT = 3'd1;
    localparam logic [2:0] ST_NEW = 3'd2;
    localparam logic [2:0] ST_REPLACE = 3'd3;
    localparam logic [2:0] ST_READ = 3'd4;

    localparam logic CFG_IGNORE_BASE = 1'b0;
    localparam logic CFG_HIT_INCREMENT = 1'b1;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] count;
        logic [RAT_W-1:0] ratio;
    } t_entry;

    // command from the sequencer to each cell
    typedef struct packed {
        logic decay;
        logic [IDX_W-1:0] decay_idx;
        logic write;
        logic [IDX_W-1:0] write_idx;
        t_entry write_data;
        logic swap;
        logic [IDX_W-1:0] swap_idx;
    } t_cell_cmd;

    typedef struct packed {
        logic mode;
        logic [31:0] pc;
        logic [IDX_W-1:0] entry_index;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [IDX_W-1:0] slot;
        logic [31:0] base_address;
        logic [31:0] hit_count;
        logic [RAT_W-1:0] hit_ratio;
        logic [31:0] total_count;
    } t_out_word;
endpackage
`default_nettype wire

[rtl/psht_stream_if.sv]
// interface: valid/ready stream carrying one word
`default_nettype none
interface psht_in_if;
    import psht_pkg::*;
    logic valid;
    logic ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface psht_out_if;
    import psht_pkg::*;
    logic valid;
    logic ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/psht_cell.sv]
// cell: one table entry, with decay, write and swap with its upper or lower neighbour
`default_nettype none
module psht_cell
    import psht_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic [IDX_W-1:0] i_my_idx,
    input wire t_cell_cmd i_cmd,
    input wire t_entry i_upper,
    input wire t_entry i_lower,
    output t_entry o_entry
);
    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.decay && i_cmd.decay_idx == i_my_idx && r_entry.count > 32'd1) begin
            n_entry.count = r_entry.count - 32'd1;
        end
        if (i_cmd.write && i_cmd.write_idx == i_my_idx) begin
            n_entry = i_cmd.write_data;
        end
        if (i_cmd.swap) begin
            if (i_cmd.swap_idx == i_my_idx) begin
                n_entry = i_lower;
            end else if (i_my_idx == i_cmd.swap_idx + IDX_W'(1)) begin
                n_entry = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

[rtl/psht_divider.sv]
// divider: restoring division of count*1024 by total, one bit a cycle
`default_nettype none
module psht_divider
    import psht_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic [31:0] i_count,
    input wire logic [31:0] i_total,
    output logic o_done,
    output logic [RAT_W-1:0] o_ratio
);
    logic [41:0] r_num;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0] r_cnt;
    logic r_busy;
    logic [32:0] w_trial;
    logic [33:0] w_sub;

    assign w_trial = {r_rem[31:0], r_num[41]};
    assign w_sub = {1'b0, w_trial} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd42;
                r_num <= {i_count, 10'd0};
                r_rem <= '0;
                r_den <= i_total;
            end else if (r_busy) begin
                if (!w_sub[33]) begin
                    r_rem <= w_sub[32:0];
                    r_num <= {r_num[40:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_num <= {r_num[40:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // quotient sits in r_num after the last step
    always_comb begin
        if (r_den == 32'd0) begin
            o_ratio = '0;
        end else if (r_num > 42'd1024) begin
            o_ratio = RAT_W'(1024);
        end else begin
            o_ratio = r_num[RAT_W-1:0];
        end
    end
endmodule
`default_nettype wire

[rtl/pc_sample_hotspot_table.sv]
// top level: hotspot table sequencer over a chain of entry cells
// channel | dir | content
// in      | in  | mode, pc, entry_index
// out     | out | status, slot, base_address, hit_count, hit_ratio, total_count
// cfg     | in  | write enable, index, 32-bit data
// a read or ignored sample is answered from idle; a record runs decay, a serial search,
// write, the serial divider, a bubble of swaps towards slot 0 and then the output state
// reset is synchronous and clears the whole table
// a stalled output word blocks the input; no new word is taken until it leaves
`default_nettype none
module pc_sample_hotspot_table
    import psht_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    psht_in_if.sink s_in,
    psht_out_if.source m_out,
    input wire logic i_cfg_we,
    input wire logic i_cfg_idx,
    input wire logic [31:0] i_cfg_data
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DECAY = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_DIV = 7'b0010000,
        S_BUBBLE = 7'b0100000,
        S_OUT = 7'b1000000
    } t_state;

    t_state r_state;
    logic [31:0] r_ign;
    logic [15:0] r_inc;
    logic [IDX_W-1:0] r_dptr;
    logic [31:0] r_total;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_free;
    logic r_free_ok;
    logic [2:0] r_status;
    logic [31:0] r_gran;
    t_out_word r_out;
    logic r_ovalid;
    t_cell_cmd w_cmd;
    t_entry w_e [ENTRIES];
    t_entry w_cur;
    logic w_div_start;
    logic w_div_done;
    logic [RAT_W-1:0] w_ratio;
    logic [31:0] w_newcnt;
    logic [31:0] w_wcount;
    logic [31:0] w_wtotal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ign <= '0;
            r_inc <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IGNORE_BASE: r_ign <= i_cfg_data;
                CFG_HIT_INCREMENT: r_inc <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            psht_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_my_idx(IDX_W'(g)), .i_cmd(w_cmd),
                .i_upper(w_e[(g == 0) ? 0 : g-1]),
                .i_lower(w_e[(g == ENTRIES-1) ? g : g+1]),
                .o_entry(w_e[g])
            );
        end
    endgenerate

    assign w_cur = w_e[r_idx];
    assign w_newcnt = w_cur.count + {16'd0, r_inc};
    // count and total as they stand once the write lands
    assign w_wcount = (r_status == ST_REPLACE) ? {16'd0, r_inc} : w_newcnt;
    assign w_wtotal = (r_status == ST_REPLACE) ? r_total - w_cur.count + {16'd0, r_inc}
                                               : r_total + {16'd0, r_inc};

    psht_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_count(w_wcount), .i_total(w_wtotal), .o_done(w_div_done), .o_ratio(w_ratio)
    );

    assign s_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.data = r_out;

    always_comb begin
        w_cmd = '0;
        w_div_start = 1'b0;
        if (r_state == S_DECAY) begin
            w_cmd.decay = 1'b1;
            w_cmd.decay_idx = r_dptr;
        end
        if (r_state == S_WRITE) begin
            w_cmd.write = 1'b1;
            w_cmd.write_idx = r_idx;
            w_cmd.write_data.base = r_gran;
            w_cmd.write_data.count = w_wcount;
            w_cmd.write_data.ratio = w_cur.ratio;
            w_div_start = 1'b1;
        end
        if (r_state == S_DIV && w_div_done) begin
            w_cmd.write = 1'b1;
            w_cmd.write_idx = r_idx;
            w_cmd.write_data = w_cur;
            w_cmd.write_data.ratio = w_ratio;
        end
        if (r_state == S_BUBBLE && r_idx != '0 && w_cur.count > w_e[r_idx - IDX_W'(1)].count)
        begin
            w_cmd.swap = 1'b1;
            w_cmd.swap_idx = r_idx - IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dptr <= '0;
            r_total <= '0;
        end else begin
            if (m_out.ready && r_ovalid) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_in.valid && s_in.ready) begin
                        r_gran <= s_in.data.pc & ~32'(GRANULE - 1);
                        if (s_in.data.mode) begin
                            r_out.status <= ST_READ;
                            r_out.slot <= s_in.data.entry_index;
                            r_out.total_count <= r_total;
                            if (s_in.data.entry_index < IDX_W'(ENTRIES)) begin
                                r_out.base_address <= w_e[s_in.data.entry_index].base;
                                r_out.hit_count <= w_e[s_in.data.entry_index].count;
                                r_out.hit_ratio <= w_e[s_in.data.entry_index].ratio;
                            end else begin
                                r_out.base_address <= '0;
                                r_out.hit_count <= '0;
                                r_out.hit_ratio <= '0;
                            end
                            r_ovalid <= 1'b1;
                        end else if (s_in.data.pc - r_ign < 32'(GRANULE)) begin
                            r_out.status <= ST_IGNORED;
                            r_out.slot <= '0;
                            r_out.base_address <= '0;
                            r_out.hit_count <= '0;
                            r_out.hit_ratio <= '0;
                            r_out.total_count <= r_total;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_state <= S_DECAY;
                        end
                    end
                end
                S_DECAY: begin
                    if (r_dptr < IDX_W'(ENTRIES) && w_e[r_dptr].count > 32'd1)
                        r_total <= r_total - 32'd1;
                    r_dptr <= (r_dptr >= IDX_W'(ENTRIES - 1)) ? '0 : r_dptr + IDX_W'(1);
                    r_idx <= '0;
                    r_free_ok <= 1'b0;
                    r_free <= '0;
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (w_cur.count != '0 && w_cur.base == r_gran) begin
                        r_status <= ST_HIT;
                        r_state <= S_WRITE;
                    end else begin
                        if (!r_free_ok && w_cur.count == '0) begin
                            r_free_ok <= 1'b1;
                            r_free <= r_idx;
                        end
                        if (r_idx == IDX_W'(ENTRIES - 1)) begin
                            r_state <= S_WRITE;
                            if (r_free_ok || w_cur.count == '0) begin
                                r_status <= ST_NEW;
                                r_idx <= r_free_ok ? r_free : r_idx;
                            end else begin
                                r_status <= ST_REPLACE;
                            end
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                S_WRITE: begin
                    r_total <= w_wtotal;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) r_state <= S_BUBBLE;
                end
                S_BUBBLE: begin
                    if (w_cmd.swap) begin
                        r_idx <= r_idx - IDX_W'(1);
                    end else begin
                        r_out.status <= r_status;
                        r_out.slot <= r_idx;
                        r_out.base_address <= w_cur.base;
                        r_out.hit_count <= w_cur.count;
                        r_out.hit_ratio <= w_cur.ratio;
                        r_out.total_count <= r_total;
                        r_ovalid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_dptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dptr < IDX_W'(ENTRIES)) else $error("decay pointer out of range");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_cmd.decay, w_cmd.write, w_cmd.swap}) <= 1)
        else $error("overlapping cell commands");
endmodule
`default_nettype wire

[verif/tb_top.sv]
// testbench: drives samples and reads into the hotspot table and checks every result word
`default_nettype none
module tb_top;
    import psht_pkg::*;

    typedef struct packed {
        logic mode;
        logic [31:0] pc;
        logic [4:0] idx;
        logic chk;
        logic [2:0] st;
        logic [4:0] slot;
        logic [31:0] base;
        logic [31:0] cnt;
        logic [10:0] rat;
        logic [31:0] tot;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [31:0] i_cfg_data = '0;

    psht_in_if s_in();
    psht_out_if m_out();

    pc_sample_hotspot_table u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in.sink), .m_out(m_out.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    logic [31:0] tbl_base [ENTRIES];
    logic [31:0] tbl_cnt [ENTRIES];
    logic [10:0] tbl_rat [ENTRIES];
    logic [4:0] decay_ptr;
    logic [31:0] total;
    logic [31:0] ign_base;
    logic [15:0] incr;

    t_out_word expected_words[$];
    t_out_word fixed_words[$];
    logic fixed_flag[$];
    int errors = 0;
    int n_words = 0;
    int n_status[5];
    int send_idle = 0;
    int recv_idle = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("timeout at %0t", $time);
        $display("[pc_sample_hotspot_table] ERROR");
        $finish;
    end

    function automatic logic [10:0] share(logic [31:0] c, logic [31:0] t);
        logic [63:0] q;
        if (t == 0) return 11'd0;
        q = {22'd0, c, 10'd0} / {32'd0, t};
        if (q > 64'd1024) q = 64'd1024;
        return q[10:0];
    endfunction

    function automatic t_out_word table_step(t_in_word w);
        t_out_word r;
        logic [31:0] g, tb, tc;
        logic [10:0] tr;
        int k, fs;
        bit hit;
        r = '0;
        if (w.mode) begin
            r.status = ST_READ;
            r.slot = w.entry_index;
            if (w.entry_index < ENTRIES) begin
                r.base_address = tbl_base[w.entry_index];
                r.hit_count = tbl_cnt[w.entry_index];
                r.hit_ratio = tbl_rat[w.entry_index];
            end
            r.total_count = total;
            return r;
        end
        if (w.pc - ign_base < GRANULE) begin
            r.status = ST_IGNORED;
            r.total_count = total;
            return r;
        end
        if (decay_ptr < ENTRIES && tbl_cnt[decay_ptr] > 1) begin
            tbl_cnt[decay_ptr] = tbl_cnt[decay_ptr] - 1;
            total = total - 1;
        end
        decay_ptr = (decay_ptr >= 5'(ENTRIES - 1)) ? 5'd0 : decay_ptr + 5'd1;
        g = w.pc & ~(GRANULE - 1);
        fs = ENTRIES;
        hit = 0;
        k = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_cnt[i] != 0 && tbl_base[i] == g) begin
                hit = 1;
                k = i;
                break;
            end
            if (fs == ENTRIES && tbl_cnt[i] == 0) fs = i;
        end
        if (hit) r.status = ST_HIT;
        else if (fs < ENTRIES) begin
            r.status = ST_NEW;
            k = fs;
        end else begin
            r.status = ST_REPLACE;
            k = ENTRIES - 1;
            total = total - tbl_cnt[k];
            tbl_cnt[k] = 0;
        end
        tbl_base[k] = g;
        total = total + incr;
        tbl_cnt[k] = tbl_cnt[k] + incr;
        tbl_rat[k] = share(tbl_cnt[k], total);
        while (k > 0 && tbl_cnt[k] > tbl_cnt[k-1]) begin
            tb = tbl_base[k]; tc = tbl_cnt[k]; tr = tbl_rat[k];
            tbl_base[k] = tbl_base[k-1]; tbl_cnt[k] = tbl_cnt[k-1];
            tbl_rat[k] = tbl_rat[k-1];
            tbl_base[k-1] = tb; tbl_cnt[k-1] = tc; tbl_rat[k-1] = tr;
            k--;
        end
        r.slot = 5'(k);
        r.base_address = tbl_base[k];
        r.hit_count = tbl_cnt[k];
        r.hit_ratio = tbl_rat[k];
        r.total_count = total;
        return r;
    endfunction

    // receiver side with random stalls
    initial begin
        m_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            m_out.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && m_out.valid && m_out.ready) begin
            n_words++;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t unexpected word %h", $time, m_out.data);
            end else begin
                e = expected_words.pop_front();
                if (fixed_flag.size() != 0 && fixed_flag.pop_front()) begin
                    if (fixed_words[0] != e) begin
                        errors++;
                        $display("%0t table row disagrees: typed %h predicted %h",
                            $time, fixed_words[0], e);
                    end
                end
                if (fixed_words.size() != 0) void'(fixed_words.pop_front());
                if (m_out.data.status <= ST_READ) n_status[m_out.data.status]++;
                if (m_out.data.status != e.status)
                    $display("%0t status exp %0d got %0d", $time, e.status,
                        m_out.data.status);
                if (m_out.data.slot != e.slot)
                    $display("%0t slot exp %0d got %0d", $time, e.slot, m_out.data.slot);
                if (m_out.data.base_address != e.base_address)
                    $display("%0t base exp %h got %h", $time, e.base_address,
                        m_out.data.base_address);
                if (m_out.data.hit_count != e.hit_count)
                    $display("%0t count exp %h got %h", $time, e.hit_count,
                        m_out.data.hit_count);
                if (m_out.data.hit_ratio != e.hit_ratio)
                    $display("%0t ratio exp %0d got %0d", $time, e.hit_ratio,
                        m_out.data.hit_ratio);
                if (m_out.data.total_count != e.total_count)
                    $display("%0t total exp %h got %h", $time, e.total_count,
                        m_out.data.total_count);
                if (m_out.data != e) errors++;
            end
        end
    end

    // valid stays up after an accept until the next word or an idle gap
    task automatic send_word(t_in_word w);
        if ($urandom_range(99) < send_idle) begin
            s_in.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.data <= w;
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
        expected_words.push_back(table_step(w));
    endtask

    task automatic drain();
        s_in.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IGNORE_BASE) ign_base = v;
        else incr = v[15:0];
    endtask

    function automatic t_in_word rand_word(logic [31:0] hot);
        t_in_word w;
        int p;
        p = $urandom_range(99);
        w.mode = (p < 12);
        w.entry_index = (p < 3) ? 5'($urandom_range(31)) : 5'($urandom_range(19));
        if (p < 70) w.pc = hot + ($urandom_range(31) << 4) + $urandom_range(15);
        else if (p < 78) w.pc = ign_base + $urandom_range(20);
        else w.pc = $urandom;
        return w;
    endfunction

    t_row rows [13] = '{
        '{1'b1, 32'h0, 5'd0, 1'b1, ST_READ, 5'd0, 32'h0, 32'h0, 11'd0, 32'h0},
        '{1'b1, 32'h0, 5'd31, 1'b1, ST_READ, 5'd31, 32'h0, 32'h0, 11'd0, 32'h0},
        '{1'b0, 32'h0000_000f, 5'd0, 1'b1, ST_IGNORED, 5'd0, 32'h0, 32'h0, 11'd0, 32'h0},
        '{1'b0, 32'hffff_ffff, 5'd0, 1'b1, ST_NEW, 5'd0, 32'hffff_fff0, 32'd100, 11'd1024,
            32'd100},
        '{1'b0, 32'hffff_fff3, 5'd0, 1'b0, 3'd0, 5'd0, 32'h0, 32'h0, 11'd0, 32'h0},
        '{1'b0, 32'h0000_0010, 5'd0, 1'b0, 3'd0, 5'd0, 32'h0, 32'h0, 11'd0, 32'h0},
        '{1'b0, 32'h0000_0010, 5'd0, 1'b0, 3'd0, 5'd0, 32'h0, 32'h0, 11'd0, 32'h0},
        '{1'b1, 32'hffff_ffff, 5'd1, 1'b0, 3'd0, 5'd0, 32'h0, 32'h0, 11'd0, 32'h0},
        '{1'b1, 32'h0, 5'd19, 1'b0, 3'd0, 5'd0, 32'h0, 32'h0, 11'd0, 32'h0},
        '{1'b1, 32'h0, 5'd20, 1'b0, 3'd0, 5'd0, 32'h0, 32'h0, 11'd0, 32'h0},
        '{1'b0, 32'h8000_0000, 5'd0, 1'b0, 3'd0, 5'd0, 32'h0, 32'h0, 11'd0, 32'h0},
        '{1'b0, 32'h5555_5555, 5'd10, 1'b0, 3'd0, 5'd0, 32'h0, 32'h0, 11'd0, 32'h0},
        '{1'b0, 32'haaaa_aaaa, 5'd21, 1'b0, 3'd0, 5'd0, 32'h0, 32'h0, 11'd0, 32'h0}
    };

    initial begin
        t_in_word w;
        t_out_word f;
        logic [31:0] hot;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_base[i] = 0; tbl_cnt[i] = 0; tbl_rat[i] = 0;
        end
        decay_ptr = 0; total = 0; ign_base = 0; incr = 16'd100;
        s_in.valid = 1'b0;
        s_in.data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            w.mode = rows[i].mode; w.pc = rows[i].pc; w.entry_index = rows[i].idx;
            f = {rows[i].st, rows[i].slot, rows[i].base, rows[i].cnt, rows[i].rat,
                rows[i].tot};
            fixed_words.push_back(f);
            fixed_flag.push_back(rows[i].chk);
            send_word(w);
        end
        // granule zero with a non-zero ignore base, then fill and evict past the last slot
        write_reg(CFG_IGNORE_BASE, 32'hffff_fff0);
        w = '0;
        fixed_words.push_back('0); fixed_flag.push_back(1'b0);
        send_word(w);
        write_reg(CFG_HIT_INCREMENT, 32'd1);
        for (int i = 0; i < 24; i++) begin
            w.mode = 0; w.pc = 32'h1000 + i * 16; w.entry_index = 0;
            send_word(w);
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 32 : (ph == 1) ? 48 : 0;
            recv_idle = (ph == 0) ? 48 : (ph == 1) ? 32 : 0;
            case (ph)
                0: begin
                    write_reg(CFG_HIT_INCREMENT, 32'd65535);
                    write_reg(CFG_IGNORE_BASE, 32'h0);
                end
                1: begin
                    write_reg(CFG_HIT_INCREMENT, 32'd1);
                    write_reg(CFG_IGNORE_BASE, 32'hffff_ffff);
                end
                default: begin
                    write_reg(CFG_HIT_INCREMENT, 32'($urandom_range(65535, 1)));
                    write_reg(CFG_IGNORE_BASE, $urandom);
                end
            endcase
            hot = $urandom & 32'hffff_f000;
            for (int n = 0; n < 215; n++) begin
                if (n == 100) drain();
                send_word(rand_word(hot));
            end
        end
        drain();
        $display("%0d words checked: %0d ignored, %0d hits, %0d new, %0d evicted, %0d reads",
            n_words, n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("[pc_sample_hotspot_table] OK");
        end else begin
            $display("%0d failures, %0d words outstanding", errors, expected_words.size());
            $display("[pc_sample_hotspot_table] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/psht_pkg.sv
rtl/psht_stream_if.sv
rtl/psht_cell.sv
rtl/psht_divider.sv
rtl/pc_sample_hotspot_table.sv
verif/tb_top.sv
